// File: rtl/lamp_radio_packet_builder_macros.svh
// Assertion macros for the lamp radio packet builder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LAMP_RADIO_PACKET_BUILDER_MACROS_SVH
`define LAMP_RADIO_PACKET_BUILDER_MACROS_SVH

// same-cycle implication
`define LRPB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lrpb_pkg.sv
// Package for the lamp radio packet builder: frame layout, constants,
// LFSR helpers and the engine control struct. No dependencies.
`timescale 1ns / 1ps

package lrpb_pkg;

    localparam logic [15:0] CRC_SEED          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'h1021;
    localparam logic [6:0]  WHITEN_SEED       = 7'h53;
    localparam int          WHITEN_LEAD_BITS  = 104;

    localparam logic [7:0]  FIXED_A           = 8'h83;
    localparam logic [7:0]  FIXED_B           = 8'h42;

    // frame positions
    localparam logic [4:0]  POS_HDR_LAST      = 5'd5;
    localparam logic [4:0]  POS_MSG_FIRST     = 5'd6;
    localparam logic [4:0]  POS_BASE_LAST     = 5'd16;
    localparam logic [4:0]  POS_CMD           = 5'd17;
    localparam logic [4:0]  POS_ID_HI         = 5'd18;
    localparam logic [4:0]  POS_ID_LO         = 5'd19;
    localparam logic [4:0]  POS_ARG1          = 5'd20;
    localparam logic [4:0]  POS_ARG2          = 5'd21;
    localparam logic [4:0]  POS_FIX_A         = 5'd22;
    localparam logic [4:0]  POS_FIX_B         = 5'd23;
    localparam logic [4:0]  POS_CRC_FIRST     = 5'd17;
    localparam logic [4:0]  POS_CRC_LAST      = 5'd28;
    localparam logic [4:0]  POS_CRC_HI        = 5'd29;
    localparam logic [4:0]  POS_MSG_LAST      = 5'd30;
    localparam logic [4:0]  POS_TRAILER       = 5'd31;

    localparam logic [2:0]  BIT_LAST          = 3'd7;

    typedef struct packed {
        logic load;
        logic step;
        logic crc_en;
        logic crc_drain;
    } lrpb_eng_ctrl_t;

    // x^7 + x^4 + 1, bit 6 out
    function automatic logic [6:0] lfsr_advance(input logic [6:0] s);
        logic [6:0] n;
        n    = {s[5:0], s[6]};
        n[4] = n[4] ^ s[6];
        return n;
    endfunction

    function automatic logic [6:0] whiten_start();
        logic [6:0] s;
        s = WHITEN_SEED;
        for (int i = 0; i < WHITEN_LEAD_BITS; i++)
        begin
            s = lfsr_advance(s);
        end
        return s;
    endfunction

    localparam logic [6:0] WHITEN_START = whiten_start();

    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h1F;
            3'd1:    b = 8'h02;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h1B;
            3'd5:    b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] msg_base_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h71;
            4'd1:    b = 8'h0F;
            4'd2:    b = 8'h55;
            4'd3:    b = 8'hAA;
            4'd4:    b = 8'h98;
            4'd5:    b = 8'h43;
            4'd6:    b = 8'hAF;
            4'd7:    b = 8'h0B;
            4'd8:    b = 8'h46;
            4'd9:    b = 8'h46;
            4'd10:   b = 8'h46;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/lrpb_bit_engine.sv
// Bit-serial CRC-16 and whitening LFSR for the packet builder.
// Depends on lrpb_pkg.
`timescale 1ns / 1ps

module lrpb_bit_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lrpb_pkg::lrpb_eng_ctrl_t ctrl,
    input  logic                    data_bit,
    output logic                    white_bit,
    output logic                    crc_msb
);
    import lrpb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [6:0]  lfsr_reg;
    logic [6:0]  lfsr_next;
    logic        crc_fb;

    assign white_bit = data_bit ^ lfsr_reg[6];
    assign crc_msb   = crc_reg[15];
    assign crc_fb    = crc_reg[15] ^ data_bit;

    always_comb
    begin
        crc_next  = crc_reg;
        lfsr_next = lfsr_reg;
        if (ctrl.load)
        begin
            crc_next  = CRC_SEED;
            lfsr_next = WHITEN_START;
        end
        else if (ctrl.step)
        begin
            lfsr_next = lfsr_advance(lfsr_reg);
            if (ctrl.crc_en)
            begin
                crc_next = {crc_reg[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'h0000);
            end
            else if (ctrl.crc_drain)
            begin
                crc_next = {crc_reg[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_SEED;
            lfsr_reg <= WHITEN_SEED;
        end
        else
        begin
            crc_reg  <= crc_next;
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

// File: rtl/lamp_radio_packet_builder.sv
// Lamp radio packet builder, top level.
// Depends on lrpb_pkg, lrpb_bit_engine and lamp_radio_packet_builder_macros.svh.
//
// Usage:
//  - Request channel: in_valid / in_stall with lamp_command, first_argument,
//    second_argument. A request is taken when in_valid is high and in_stall low.
//  - Output channel: out_valid / out_stall with frame_byte, byte_position,
//    last_byte. Each request yields 32 bytes in frame order; last_byte marks 31.
//  - Config channel: cfg_valid / cfg_ready with lamp_address; write only while idle.
//  - An accepted request moves the block to the plain state, from which the
//    first byte is loaded into the output register. Without backpressure,
//    6 header bytes go out at one per cycle, 25 message bytes pass bit by bit
//    through the bit-serial CRC/whitening engine, and 1 trailer byte follows.
//  - in_stall stays high from the accepted request until the trailer byte is
//    loaded into the output register.
//  - When out_stall is high the output register holds its byte and the bit
//    engine pauses before completing the next byte.
//  - Reset clears lamp_address to zero and returns the block to idle.
`timescale 1ns / 1ps
`include "lamp_radio_packet_builder_macros.svh"

module lamp_radio_packet_builder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] lamp_command,
    input  logic [7:0] first_argument,
    input  logic [7:0] second_argument,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic [4:0] byte_position,
    output logic       last_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [15:0] lamp_address
);
    import lrpb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAIN,
        ST_WHITEN
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  white_sr_reg, white_sr_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  arg1_reg, arg1_next;
    logic [7:0]  arg2_reg, arg2_next;
    logic [15:0] lamp_address_reg, lamp_address_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  frame_byte_reg, frame_byte_next;
    logic [4:0]  byte_position_reg, byte_position_next;
    logic        last_byte_reg, last_byte_next;

    lrpb_eng_ctrl_t eng_ctrl;
    logic           data_bit;
    logic           white_bit;
    logic           crc_msb;
    logic           out_load_ok;
    logic [7:0]     msg_byte;
    logic [7:0]     plain_byte;
    logic [7:0]     white_byte;
    logic [4:0]     base_idx;

    lrpb_bit_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (eng_ctrl),
        .data_bit  (data_bit),
        .white_bit (white_bit),
        .crc_msb   (crc_msb)
    );

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign byte_position = byte_position_reg;
    assign last_byte     = last_byte_reg;

    assign out_load_ok = !out_valid_reg || !out_stall;
    assign base_idx    = pos_reg - POS_MSG_FIRST;
    assign plain_byte  = (pos_reg <= POS_HDR_LAST) ? header_byte(pos_reg[2:0]) : 8'h00;
    assign white_byte  = {white_bit, white_sr_reg[7:1]};

    always_comb
    begin
        case (pos_reg)
            POS_CMD:   msg_byte = cmd_reg;
            POS_ID_HI: msg_byte = lamp_address_reg[15:8];
            POS_ID_LO: msg_byte = lamp_address_reg[7:0];
            POS_ARG1:  msg_byte = arg1_reg;
            POS_ARG2:  msg_byte = arg2_reg;
            POS_FIX_A: msg_byte = FIXED_A;
            POS_FIX_B: msg_byte = FIXED_B;
            default:
            begin
                if (pos_reg >= POS_MSG_FIRST && pos_reg <= POS_BASE_LAST)
                    msg_byte = msg_base_byte(base_idx[3:0]);
                else
                    msg_byte = 8'h00;
            end
        endcase
    end

    // CRC bytes come straight out of the CRC register, MSB first
    assign data_bit = (pos_reg >= POS_CRC_HI) ? crc_msb : msg_byte[~bit_cnt_reg];

    always_comb
    begin
        state_next         = state_reg;
        pos_next           = pos_reg;
        bit_cnt_next       = bit_cnt_reg;
        white_sr_next      = white_sr_reg;
        cmd_next           = cmd_reg;
        arg1_next          = arg1_reg;
        arg2_next          = arg2_reg;
        lamp_address_next  = lamp_address_reg;
        out_valid_next     = out_valid_reg;
        frame_byte_next    = frame_byte_reg;
        byte_position_next = byte_position_reg;
        last_byte_next     = last_byte_reg;
        eng_ctrl           = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid && cfg_ready)
            lamp_address_next = lamp_address;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = lamp_command;
                    arg1_next     = first_argument;
                    arg2_next     = second_argument;
                    eng_ctrl.load = 1'b1;
                    pos_next      = '0;
                    state_next    = ST_PLAIN;
                end
            end
            ST_PLAIN:
            begin
                if (out_load_ok)
                begin
                    out_valid_next     = 1'b1;
                    frame_byte_next    = plain_byte;
                    byte_position_next = pos_reg;
                    last_byte_next     = (pos_reg == POS_TRAILER);
                    pos_next           = pos_reg + 5'd1;
                    if (pos_reg == POS_TRAILER)
                        state_next = ST_IDLE;
                    else if (pos_reg == POS_HDR_LAST)
                    begin
                        state_next   = ST_WHITEN;
                        bit_cnt_next = '0;
                    end
                end
            end
            ST_WHITEN:
            begin
                if (bit_cnt_reg != BIT_LAST || out_load_ok)
                begin
                    eng_ctrl.step      = 1'b1;
                    eng_ctrl.crc_en    = (pos_reg >= POS_CRC_FIRST) && (pos_reg <= POS_CRC_LAST);
                    eng_ctrl.crc_drain = (pos_reg >= POS_CRC_HI);
                    white_sr_next      = white_byte;
                    bit_cnt_next       = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == BIT_LAST)
                    begin
                        out_valid_next     = 1'b1;
                        frame_byte_next    = white_byte;
                        byte_position_next = pos_reg;
                        last_byte_next     = 1'b0;
                        pos_next           = pos_reg + 5'd1;
                        if (pos_reg == POS_MSG_LAST)
                            state_next = ST_PLAIN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pos_reg           <= '0;
            bit_cnt_reg       <= '0;
            white_sr_reg      <= '0;
            cmd_reg           <= '0;
            arg1_reg          <= '0;
            arg2_reg          <= '0;
            lamp_address_reg  <= '0;
            out_valid_reg     <= 1'b0;
            frame_byte_reg    <= '0;
            byte_position_reg <= '0;
            last_byte_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pos_reg           <= pos_next;
            bit_cnt_reg       <= bit_cnt_next;
            white_sr_reg      <= white_sr_next;
            cmd_reg           <= cmd_next;
            arg1_reg          <= arg1_next;
            arg2_reg          <= arg2_next;
            lamp_address_reg  <= lamp_address_next;
            out_valid_reg     <= out_valid_next;
            frame_byte_reg    <= frame_byte_next;
            byte_position_reg <= byte_position_next;
            last_byte_reg     <= last_byte_next;
        end
    end

    `LRPB_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall,
                      "not busy after request")
    `LRPB_ASSERT_SAME(a_whiten_range, state_reg == ST_WHITEN,
                      pos_reg >= POS_MSG_FIRST && pos_reg <= POS_MSG_LAST, "whitening outside message")
    `LRPB_ASSERT_SAME(a_idle_holds_trailer, !in_stall && out_valid, last_byte, "idle with frame pending")
    `LRPB_ASSERT_SAME(a_last_at_end, out_valid && last_byte, byte_position == POS_TRAILER,
                      "last byte misplaced")

endmodule

// File: verif/lamp_radio_packet_builder_checker.sv
// Checker for the lamp radio packet builder: watches the request, frame and
// config channels, predicts each 32-byte frame and compares it byte by byte.
// Depends on lrpb_pkg for the CRC and whitening constants.
`timescale 1ns / 1ps

module lamp_radio_packet_builder_checker
    import lrpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  lamp_command,
    input  logic [7:0]  first_argument,
    input  logic [7:0]  second_argument,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  frame_byte,
    input  logic [4:0]  byte_position,
    input  logic        last_byte,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] lamp_address,
    output int          mismatch_count,
    output int          bytes_pending,
    output int          bytes_checked
);

    localparam int FRAME_BYTES = 32;
    localparam int MSG_BYTES   = 25;
    localparam int MSG_OFFSET  = 6;
    localparam int CRC_FIRST   = 11;
    localparam int CRC_END     = 23;
    localparam int PRINT_CAP   = 40;

    localparam logic [7:0] ADV_HEADER [6] = '{8'h1F, 8'h02, 8'h01, 8'h01, 8'h1B, 8'h03};
    localparam logic [7:0] MSG_PREFIX [11] =
        '{8'h71, 8'h0F, 8'h55, 8'hAA, 8'h98, 8'h43, 8'hAF, 8'h0B, 8'h46, 8'h46, 8'h46};

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] pos;
        logic       last;
    } frame_beat_t;

    frame_beat_t expected_frame_bytes [$];
    logic [15:0] lamp_id = 16'h0000;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    // x^7 + x^4 + 1, bit 6 shifts out and feeds bits 0 and 4
    function automatic logic [6:0] whitener_shift(input logic [6:0] s);
        return {s[5:4], s[3] ^ s[6], s[2:0], s[6]};
    endfunction

    function automatic logic [31:0][7:0] whitened_frame(input logic [7:0] cmd, a1, a2,
                                                        input logic [15:0] id);
        logic [24:0][7:0] msg;
        logic [31:0][7:0] frame;
        logic [15:0]      crc;
        logic [6:0]       lfsr;
        msg = '0;
        for (int i = 0; i < 11; i++)
            msg[i] = MSG_PREFIX[i];
        msg[11] = cmd;
        msg[12] = id[15:8];
        msg[13] = id[7:0];
        msg[14] = a1;
        msg[15] = a2;
        msg[16] = FIXED_A;
        msg[17] = FIXED_B;
        crc = CRC_SEED;
        for (int i = CRC_FIRST; i < CRC_END; i++)
            crc = crc16_byte(crc, msg[i]);
        msg[23] = crc[15:8];
        msg[24] = crc[7:0];
        lfsr = WHITEN_SEED;
        for (int i = 0; i < WHITEN_LEAD_BITS; i++)
            lfsr = whitener_shift(lfsr);
        frame = '0;
        for (int i = 0; i < 6; i++)
            frame[i] = ADV_HEADER[i];
        // bytes go out reversed, so bit b of the result comes from bit 7-b
        for (int i = 0; i < MSG_BYTES; i++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                frame[MSG_OFFSET + i][b] = msg[i][7 - b] ^ lfsr[6];
                lfsr = whitener_shift(lfsr);
            end
        end
        return frame;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [31:0][7:0] frame;
        frame_beat_t      beat;
        if (!rst_n)
        begin
            lamp_id = 16'h0000;
            expected_frame_bytes.delete();
            mismatch_count = 0;
            bytes_pending = 0;
            bytes_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                lamp_id = lamp_address;
            if (in_valid && !in_stall)
            begin
                frame = whitened_frame(lamp_command, first_argument, second_argument, lamp_id);
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    beat.data = frame[i];
                    beat.pos  = 5'(i);
                    beat.last = (i == FRAME_BYTES - 1);
                    expected_frame_bytes.push_back(beat);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_frame_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected byte %02h at position %0d",
                                              frame_byte, byte_position));
                else
                begin
                    beat = expected_frame_bytes.pop_front();
                    if (frame_byte !== beat.data)
                        report_mismatch($sformatf("position %0d: frame_byte %02h, expected %02h",
                                                  beat.pos, frame_byte, beat.data));
                    if (byte_position !== beat.pos)
                        report_mismatch($sformatf("byte_position %0d, expected %0d",
                                                  byte_position, beat.pos));
                    if (last_byte !== beat.last)
                        report_mismatch($sformatf("position %0d: last_byte %0b, expected %0b",
                                                  beat.pos, last_byte, beat.last));
                    bytes_checked++;
                end
            end
            bytes_pending = expected_frame_bytes.size();
        end
    end

endmodule

// File: verif/lamp_radio_packet_builder_tb.sv
// Testbench top for the lamp radio packet builder: clock, reset, requests,
// lamp address writes and random output stalls; checking sits in the checker.
// Depends on lamp_radio_packet_builder and lamp_radio_packet_builder_checker.
`timescale 1ns / 1ps

module lamp_radio_packet_builder_tb;

    localparam int CYCLE_LIMIT     = 1500000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 30;

    localparam logic [23:0] DIRECTED_FIELDS [5] =
        '{24'h000000, 24'hFFFFFF, 24'h55AA55, 24'hAA55AA, 24'h0180FE};
    localparam logic [15:0] DIRECTED_IDS [4] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  lamp_command = 8'h00;
    logic [7:0]  first_argument = 8'h00;
    logic [7:0]  second_argument = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic [4:0]  byte_position;
    logic        last_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] lamp_address = 16'h0000;

    int          mismatch_count;
    int          bytes_pending;
    int          bytes_checked;
    int          requests_sent = 0;
    int          ids_written = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    int          stall_draw;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    always #2 clk = ~clk;

    lamp_radio_packet_builder u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .lamp_command    (lamp_command),
        .first_argument  (first_argument),
        .second_argument (second_argument),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_byte      (frame_byte),
        .byte_position   (byte_position),
        .last_byte       (last_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .lamp_address    (lamp_address)
    );

    lamp_radio_packet_builder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .lamp_command    (lamp_command),
        .first_argument  (first_argument),
        .second_argument (second_argument),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_byte      (frame_byte),
        .byte_position   (byte_position),
        .last_byte       (last_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .lamp_address    (lamp_address),
        .mismatch_count  (mismatch_count),
        .bytes_pending   (bytes_pending),
        .bytes_checked   (bytes_checked)
    );

    // receiver: after each accepted byte, hold stall for a drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            stall_draw = rx_quiet ? 0 : $urandom_range(0, 19);
            out_stall <= (stall_draw != 0);
            stall_left <= stall_draw;
            if (last_byte)
                rx_quiet = ($urandom_range(0, 3) == 0);
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped: no completion within %0d cycles", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] random_field();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [7:0] cmd, a1, a2);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        lamp_command <= cmd;
        first_argument <= a1;
        second_argument <= a2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_lamp_address(input logic [15:0] value);
        cfg_valid <= 1'b1;
        lamp_address <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ids_written++;
    endtask

    initial
    begin : stimulus
        logic [15:0] lamp_id;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes under zero, all-ones and mixed lamp addresses
        for (int p = 0; p < 4; p++)
        begin
            write_lamp_address(DIRECTED_IDS[p]);
            tx_quiet = (p == 1);
            for (int i = 0; i < 5; i++)
                send_request(DIRECTED_FIELDS[i][23:16], DIRECTED_FIELDS[i][15:8],
                             DIRECTED_FIELDS[i][7:0]);
            drain_frames();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                lamp_id = 16'h0000;
            else if (p == RANDOM_PHASES - 1)
                lamp_id = 16'hFFFF;
            else
                lamp_id = 16'($urandom);
            write_lamp_address(lamp_id);
            tx_quiet = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE)
                send_request(random_field(), random_field(), random_field());
            drain_frames();
        end

        repeat (40) @(posedge clk);
        $display("requests: %0d under %0d lamp address writes, including zero and all ones",
                 requests_sent, ids_written);
        $display("frame bytes compared: %0d, mismatches: %0d", bytes_checked, mismatch_count);
        if (mismatch_count == 0 && bytes_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
